// ===== design/apcs_pkg.sv =====
`default_nettype none
package apcs_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int NUM_DRIVES       = 4;
    localparam int MAX_DRIVES       = 4;
    localparam int MAX_RESULTS      = 12;
    localparam int RES_IDX_W        = 4;
    localparam int LIMIT_W          = 17;
    localparam logic [LIMIT_W-1:0] POLL_LIMIT_RST = 17'd100000;

    // request kinds
    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_IDENT = 3'd2;
    localparam logic [2:0] REQ_REPLY = 3'd3;
    localparam logic [2:0] REQ_HWORD = 3'd4;

    // result kinds
    localparam logic [1:0] K_BUS_RD = 2'd0;
    localparam logic [1:0] K_BUS_WR = 2'd1;
    localparam logic [1:0] K_DATA   = 2'd2;
    localparam logic [1:0] K_DONE   = 2'd3;

    // completion codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ABSENT  = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_DEV_ERR = 3'd3;
    localparam logic [2:0] ST_NOT_ATA = 3'd4;

    // task-file offsets
    localparam logic [9:0] OFF_DATA   = 10'd0;
    localparam logic [9:0] OFF_SECCNT = 10'd2;
    localparam logic [9:0] OFF_LBA0   = 10'd3;
    localparam logic [9:0] OFF_LBA1   = 10'd4;
    localparam logic [9:0] OFF_LBA2   = 10'd5;
    localparam logic [9:0] OFF_DRIVE  = 10'd6;
    localparam logic [9:0] OFF_CMD    = 10'd7;
    localparam logic [9:0] OFF_ALT    = 10'h206;

    // commands and status bits
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_IDENT = 8'hEC;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;
    localparam logic [7:0] DEV_LBA   = 8'hE0;
    localparam logic [7:0] DEV_ID_M  = 8'hA0;
    localparam logic [7:0] DEV_ID_S  = 8'hB0;
    localparam logic [7:0] SR_BSY    = 8'h80;
    localparam logic [7:0] SR_ERRDF  = 8'h21;
    localparam logic [7:0] SR_ERR    = 8'h01;
    localparam logic [7:0] SR_DRQ    = 8'h08;

    localparam logic [7:0] ID_WORD_LO = 8'd60;
    localparam logic [7:0] ID_WORD_HI = 8'd61;

    typedef enum logic [10:0] {
        PH_IDLE     = 11'b00000000001,
        PH_POLL     = 11'b00000000010,
        PH_RD_DATA  = 11'b00000000100,
        PH_WR_DATA  = 11'b00000001000,
        PH_FLUSH    = 11'b00000010000,
        PH_ID_STAT0 = 11'b00000100000,
        PH_ID_BSY   = 11'b00001000000,
        PH_ID_MID   = 11'b00010000000,
        PH_ID_HIGH  = 11'b00100000000,
        PH_ID_DRQ   = 11'b01000000000,
        PH_ID_DATA  = 11'b10000000000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [1:0]         op;
        logic               chan;
        logic               slave;
        logic [LIMIT_W-1:0] poll_cnt;
        logic [7:0]         word_idx;
        logic [7:0]         sec_left;
        logic [31:0]        accum;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  off;
        logic [15:0] data;
        logic [2:0]  code;
        logic [31:0] total;
    } res_item_t;

    typedef struct packed {
        res_item_t [MAX_RESULTS-1:0] items;
        logic [RES_IDX_W-1:0]        count;
        logic                        chan;
    } res_batch_t;

endpackage
`default_nettype wire

// ===== design/apcs_step.sv =====
`default_nettype none
module apcs_step #(
    parameter int NUM_DRIVES = apcs_pkg::NUM_DRIVES
) (
    input  wire apcs_pkg::seq_state_t       st,
    input  wire logic [NUM_DRIVES-1:0]      present,
    input  wire logic [apcs_pkg::LIMIT_W-1:0] poll_limit,
    input  wire logic [2:0]                 req_type,
    input  wire logic                       channel,
    input  wire logic                       slave,
    input  wire logic [27:0]                lba,
    input  wire logic [7:0]                 count,
    input  wire logic [15:0]                data_word,
    output apcs_pkg::seq_state_t            st_next,
    output logic [NUM_DRIVES-1:0]           present_next,
    output apcs_pkg::res_batch_t            batch
);

    function automatic apcs_pkg::res_item_t mk(input logic [1:0] k, input logic [9:0] o,
                                               input logic [15:0] d, input logic [2:0] c,
                                               input logic [31:0] t);
        apcs_pkg::res_item_t r;
        r.kind  = k;
        r.off   = o;
        r.data  = d;
        r.code  = c;
        r.total = t;
        return r;
    endfunction

    logic [apcs_pkg::LIMIT_W-1:0] lim_m1;
    assign lim_m1 = (poll_limit == '0) ? '0 : poll_limit - 1'b1;

    always_comb begin
        apcs_pkg::seq_state_t        s;
        logic [apcs_pkg::MAX_DRIVES-1:0] pres4;
        logic [apcs_pkg::RES_IDX_W-1:0]  n;
        logic [1:0]                   idx;
        logic [7:0]                   sr;
        logic                         in_range;
        logic                         eos;
        logic [7:0]                   dev;

        s     = st;
        pres4 = apcs_pkg::MAX_DRIVES'(present);
        n     = '0;
        batch.items = '0;
        sr    = data_word[7:0];
        eos   = 1'b0;
        idx   = 2'b00;
        in_range = 1'b0;
        dev   = '0;

        if (req_type <= apcs_pkg::REQ_IDENT) begin
            if (st.phase == apcs_pkg::PH_IDLE) begin
                s.chan  = channel;
                s.slave = slave;
                s.op    = req_type[1:0];
                idx     = {channel, slave};
                in_range = 32'(idx) < NUM_DRIVES;
                if (req_type == apcs_pkg::REQ_IDENT) begin
                    if (!in_range) begin
                        batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_ABSENT, '0);
                        n = n + 1'b1;
                    end else begin
                        pres4[idx] = 1'b0;
                        s.accum = '0;
                        batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_DRIVE,
                            {8'h00, slave ? apcs_pkg::DEV_ID_S : apcs_pkg::DEV_ID_M}, '0, '0);
                        n = n + 1'b1;
                        for (int i = 0; i < 4; i++) begin
                            batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_ALT, '0, '0, '0);
                            n = n + 1'b1;
                        end
                        batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_SECCNT, '0, '0, '0);
                        n = n + 1'b1;
                        batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_LBA0, '0, '0, '0);
                        n = n + 1'b1;
                        batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_LBA1, '0, '0, '0);
                        n = n + 1'b1;
                        batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_LBA2, '0, '0, '0);
                        n = n + 1'b1;
                        batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_CMD,
                                            {8'h00, apcs_pkg::CMD_IDENT}, '0, '0);
                        n = n + 1'b1;
                        batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_CMD, '0, '0, '0);
                        n = n + 1'b1;
                        s.phase = apcs_pkg::PH_ID_STAT0;
                    end
                end else if (!in_range || !pres4[idx]) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_ABSENT, '0);
                    n = n + 1'b1;
                end else begin
                    dev = apcs_pkg::DEV_LBA | {3'b000, slave, lba[27:24]};
                    batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_DRIVE,
                                        {8'h00, dev}, '0, '0);
                    n = n + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_SECCNT,
                                        {8'h00, count}, '0, '0);
                    n = n + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_LBA0,
                                        {8'h00, lba[7:0]}, '0, '0);
                    n = n + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_LBA1,
                                        {8'h00, lba[15:8]}, '0, '0);
                    n = n + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_LBA2,
                                        {8'h00, lba[23:16]}, '0, '0);
                    n = n + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_CMD,
                        {8'h00, (req_type == apcs_pkg::REQ_READ) ? apcs_pkg::CMD_READ
                                                                 : apcs_pkg::CMD_WRITE},
                        '0, '0);
                    n = n + 1'b1;
                    s.sec_left = count;
                    s.word_idx = '0;
                    if (count == '0) begin
                        if (req_type == apcs_pkg::REQ_WRITE) begin
                            batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_CMD,
                                                {8'h00, apcs_pkg::CMD_FLUSH}, '0, '0);
                            n = n + 1'b1;
                            s.phase = apcs_pkg::PH_FLUSH;
                        end else begin
                            batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_OK, '0);
                            n = n + 1'b1;
                            s.phase = apcs_pkg::PH_IDLE;
                        end
                    end else begin
                        s.phase = apcs_pkg::PH_POLL;
                    end
                    // poll start (alt-status delay reads, first status read)
                    if (s.phase != apcs_pkg::PH_IDLE) begin
                        for (int i = 0; i < 4; i++) begin
                            batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_ALT, '0, '0, '0);
                            n = n + 1'b1;
                        end
                        s.poll_cnt = '0;
                        if (lim_m1 == '0) begin
                            batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0,
                                (s.phase == apcs_pkg::PH_FLUSH) ? apcs_pkg::ST_OK
                                                                : apcs_pkg::ST_TIMEOUT, '0);
                            n = n + 1'b1;
                            s.phase = apcs_pkg::PH_IDLE;
                        end else begin
                            s.poll_cnt = 17'd1;
                            batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_CMD, '0, '0, '0);
                            n = n + 1'b1;
                        end
                    end
                end
            end
        end else if (req_type == apcs_pkg::REQ_REPLY) begin
            idx = {st.chan, st.slave};
            if (st.phase == apcs_pkg::PH_POLL || st.phase == apcs_pkg::PH_FLUSH) begin
                if ((sr & apcs_pkg::SR_BSY) != '0) begin
                    if (st.poll_cnt < lim_m1) begin
                        s.poll_cnt = st.poll_cnt + 1'b1;
                        batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_CMD, '0, '0, '0);
                        n = n + 1'b1;
                    end else begin
                        batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0,
                            (st.phase == apcs_pkg::PH_FLUSH) ? apcs_pkg::ST_OK
                                                             : apcs_pkg::ST_TIMEOUT, '0);
                        n = n + 1'b1;
                        s.phase = apcs_pkg::PH_IDLE;
                    end
                end else if (st.phase == apcs_pkg::PH_FLUSH) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_OK, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else if ((sr & apcs_pkg::SR_ERRDF) != '0) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_DEV_ERR, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else begin
                    s.word_idx = '0;
                    if (st.op == apcs_pkg::REQ_READ[1:0]) begin
                        batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_DATA, '0, '0, '0);
                        n = n + 1'b1;
                        s.phase = apcs_pkg::PH_RD_DATA;
                    end else begin
                        s.phase = apcs_pkg::PH_WR_DATA;
                    end
                end
            end else if (st.phase == apcs_pkg::PH_RD_DATA) begin
                batch.items[n] = mk(apcs_pkg::K_DATA, '0, data_word, '0, '0);
                n = n + 1'b1;
                if (st.word_idx == 8'(apcs_pkg::WORDS_PER_SECTOR - 1)) begin
                    eos = 1'b1;
                end else begin
                    s.word_idx = st.word_idx + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_DATA, '0, '0, '0);
                    n = n + 1'b1;
                end
            end else if (st.phase == apcs_pkg::PH_ID_STAT0) begin
                if (sr == '0) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_ABSENT, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else if (lim_m1 == '0) begin
                    s.poll_cnt = '0;
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_TIMEOUT, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else begin
                    s.poll_cnt = 17'd1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_CMD, '0, '0, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_ID_BSY;
                end
            end else if (st.phase == apcs_pkg::PH_ID_BSY || st.phase == apcs_pkg::PH_ID_DRQ
                         || st.phase == apcs_pkg::PH_ID_HIGH) begin
                if (st.phase == apcs_pkg::PH_ID_BSY && (sr & apcs_pkg::SR_BSY) == '0) begin
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_LBA1, '0, '0, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_ID_MID;
                end else if (st.phase == apcs_pkg::PH_ID_HIGH && sr != '0) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_NOT_ATA, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else if (st.phase == apcs_pkg::PH_ID_DRQ &&
                             (sr & apcs_pkg::SR_ERR) != '0) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_DEV_ERR, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else if (st.phase == apcs_pkg::PH_ID_DRQ &&
                             (sr & apcs_pkg::SR_DRQ) != '0) begin
                    s.word_idx = '0;
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_DATA, '0, '0, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_ID_DATA;
                end else if (st.poll_cnt < lim_m1) begin
                    // still busy, waiting on DRQ, or LBA high read as zero: another status read
                    s.poll_cnt = st.poll_cnt + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_CMD, '0, '0, '0);
                    n = n + 1'b1;
                    if (st.phase == apcs_pkg::PH_ID_HIGH) begin
                        s.phase = apcs_pkg::PH_ID_DRQ;
                    end
                end else begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_TIMEOUT, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end
            end else if (st.phase == apcs_pkg::PH_ID_MID) begin
                if (sr != '0) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_NOT_ATA, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else begin
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_LBA2, '0, '0, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_ID_HIGH;
                end
            end else if (st.phase == apcs_pkg::PH_ID_DATA) begin
                if (st.word_idx == apcs_pkg::ID_WORD_LO) begin
                    s.accum = {st.accum[31:16], data_word};
                end else if (st.word_idx == apcs_pkg::ID_WORD_HI) begin
                    s.accum = {data_word, st.accum[15:0]};
                end
                if (st.word_idx == 8'(apcs_pkg::WORDS_PER_SECTOR - 1)) begin
                    s.word_idx = '0;
                    if (32'(idx) < NUM_DRIVES) begin
                        pres4[idx] = 1'b1;
                    end
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_OK, s.accum);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else begin
                    s.word_idx = st.word_idx + 1'b1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_DATA, '0, '0, '0);
                    n = n + 1'b1;
                end
            end
        end else if (req_type == apcs_pkg::REQ_HWORD) begin
            if (st.phase == apcs_pkg::PH_WR_DATA) begin
                batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_DATA, data_word, '0, '0);
                n = n + 1'b1;
                if (st.word_idx == 8'(apcs_pkg::WORDS_PER_SECTOR - 1)) begin
                    eos = 1'b1;
                end else begin
                    s.word_idx = st.word_idx + 1'b1;
                end
            end
        end

        // end of sector: next sector poll, flush, or done
        if (eos) begin
            s.word_idx = '0;
            s.sec_left = st.sec_left - 1'b1;
            if (s.sec_left == '0 && st.op != apcs_pkg::REQ_WRITE[1:0]) begin
                batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0, apcs_pkg::ST_OK, '0);
                n = n + 1'b1;
                s.phase = apcs_pkg::PH_IDLE;
            end else begin
                if (s.sec_left == '0) begin
                    batch.items[n] = mk(apcs_pkg::K_BUS_WR, apcs_pkg::OFF_CMD,
                                        {8'h00, apcs_pkg::CMD_FLUSH}, '0, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_FLUSH;
                end else begin
                    s.phase = apcs_pkg::PH_POLL;
                end
                for (int i = 0; i < 4; i++) begin
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_ALT, '0, '0, '0);
                    n = n + 1'b1;
                end
                s.poll_cnt = '0;
                if (lim_m1 == '0) begin
                    batch.items[n] = mk(apcs_pkg::K_DONE, '0, '0,
                        (s.phase == apcs_pkg::PH_FLUSH) ? apcs_pkg::ST_OK
                                                        : apcs_pkg::ST_TIMEOUT, '0);
                    n = n + 1'b1;
                    s.phase = apcs_pkg::PH_IDLE;
                end else begin
                    s.poll_cnt = 17'd1;
                    batch.items[n] = mk(apcs_pkg::K_BUS_RD, apcs_pkg::OFF_CMD, '0, '0, '0);
                    n = n + 1'b1;
                end
            end
        end

        st_next      = s;
        present_next = pres4[NUM_DRIVES-1:0];
        batch.count  = n;
        batch.chan   = s.chan;
    end

endmodule
`default_nettype wire

// ===== design/ata_pio_command_sequencer.sv =====
`default_nettype none
// Latency: an accepted beat's first result beat is on m_* the next cycle.
// Throughput: one request beat per cycle when it yields at most one result
//   and m_tready is high; a request yielding N result beats (up to 12)
//   holds the input until the single output port drains the result buffer.
// Reset: synchronous, active-low aresetn; sequencer idle, present map cleared,
//   poll limit back to 100000, result buffer empty.
module ata_pio_command_sequencer #(
    parameter int NUM_DRIVES = apcs_pkg::NUM_DRIVES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: poll_limit
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] channel, [1] slave, [29:2] lba, [37:30] count, [53:38] data_word
    input  wire logic [55:0] s_tdata,
    // [2:0] req_type
    input  wire logic [2:0]  s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] bus_channel, [10:1] reg_offset, [26:11] out_data,
    // [29:27] status_code, [61:30] sector_total
    output logic [63:0]      m_tdata,
    // [1:0] kind
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    logic [apcs_pkg::LIMIT_W-1:0] poll_limit_reg;
    apcs_pkg::seq_state_t         st_reg, st_next;
    logic [NUM_DRIVES-1:0]        present_reg, present_next;
    apcs_pkg::res_batch_t         batch_next, batch_reg;
    logic [apcs_pkg::RES_IDX_W-1:0] pos_reg;
    logic                         busy_reg;
    logic                         s_beat, m_beat, last_beat;
    apcs_pkg::res_item_t          cur;

    // sequencer step: state and request beat in, next state and result batch out
    apcs_step #(.NUM_DRIVES(NUM_DRIVES)) u_step (
        .st           (st_reg),
        .present      (present_reg),
        .poll_limit   (poll_limit_reg),
        .req_type     (s_tuser),
        .channel      (s_tdata[0]),
        .slave        (s_tdata[1]),
        .lba          (s_tdata[29:2]),
        .count        (s_tdata[37:30]),
        .data_word    (s_tdata[53:38]),
        .st_next      (st_next),
        .present_next (present_next),
        .batch        (batch_next)
    );

    assign m_beat    = m_tvalid && m_tready;
    assign last_beat = (pos_reg == batch_reg.count - 1'b1);
    // input free when the buffer is empty or its final beat leaves now
    assign s_tready  = !busy_reg || (m_beat && last_beat);
    assign s_beat    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg <= apcs_pkg::POLL_LIMIT_RST;
        end else if (cfg_we) begin
            poll_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '{phase: apcs_pkg::PH_IDLE, default: '0};
            present_reg <= '0;
            busy_reg    <= 1'b0;
            pos_reg     <= '0;
        end else begin
            if (s_beat) begin
                st_reg      <= st_next;
                present_reg <= present_next;
                busy_reg    <= (batch_next.count != '0);
                pos_reg     <= '0;
            end else if (m_beat) begin
                if (last_beat) begin
                    busy_reg <= 1'b0;
                end
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // result buffer payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            batch_reg <= batch_next;
        end
    end

    assign cur      = batch_reg.items[pos_reg];
    assign m_tvalid = busy_reg;
    assign m_tlast  = last_beat;
    assign m_tuser  = cur.kind;
    assign m_tdata  = {2'b00, cur.total, cur.code, cur.data, cur.off, batch_reg.chan};

    a_pos_in_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg < batch_reg.count))
        else $error("result position beyond batch");

    a_no_accept_mid_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !(m_beat && last_beat)) |-> !s_tready)
        else $error("request accepted while batch pending");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(pos_reg) && m_tvalid))
        else $error("stalled result moved");

endmodule
`default_nettype wire
